### src/afsa_pkg.sv
// ----------------------------------------------------------------------------
// afsa_pkg
// Types and constants shared by the actuator fault status aggregator.
// ----------------------------------------------------------------------------
package afsa_pkg;

    localparam int FLAG_W  = 30;
    localparam int IDX_W   = 8;
    localparam int WORD_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 4;

    typedef enum logic [1:0] {
        CMD_SERVER = 2'd0,
        CMD_DEMAND = 2'd1,
        CMD_DCA    = 2'd2,
        CMD_LOG    = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [IDX_W-1:0]   actuator_index;
        logic [WORD_W-1:0]  status_word;
        logic [WORD_W-1:0]  fault_word;
        logic [COUNT_W-1:0] broadcast_count;
    } in_word_t;

    typedef struct packed {
        logic [FLAG_W-1:0] any_flags;
        logic              any_warning;
    } out_word_t;

    typedef struct packed {
        logic [FLAG_W-1:0] flags;
        logic [WORD_W-1:0] server;
        logic [BYTE_W-1:0] demand;
        logic [WORD_W-1:0] dca;
    } entry_t;

    localparam entry_t RESET_ENTRY = '{
        flags:  '0,
        server: 16'hFFFF,
        demand: 8'hFF,
        dca:    16'hFFFF
    };

endpackage

### src/actuator_fault_status_aggregator_top.sv
// ----------------------------------------------------------------------------
// actuator_fault_status_aggregator_top
// Status word read-modify-write on a per-actuator memory and aggregate walk.
// ----------------------------------------------------------------------------
// status word: memory read, then modify and write back
// log word while pending: a walk with one memory read per actuator; the result
// waits while the previous result still waits on m_ready
// log word while not pending or status word with index out of range: taken with no memory access
// reset: synchronous; a clearing pass then writes every entry, one per cycle, with s_ready low
module actuator_fault_status_aggregator_top
    import afsa_pkg::*;
#(
    parameter int ACTUATORS = 256
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int AW = (ACTUATORS > 1) ? $clog2(ACTUATORS) : 1;
    localparam int EW = AW + IDX_W;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_RMW   = 5'b00100,
        ST_WALK  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic              pending_reg, pending_next;
    logic              walk_data_reg, walk_data_next;
    logic [FLAG_W-1:0] acc_reg, acc_next;
    in_word_t          item_reg, item_next;
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_data_reg, m_data_next;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    entry_t        wr_data, rd_data, upd_entry;
    logic          upd_changed;
    logic [EW-1:0] idx_ext;
    logic          idx_ok;
    logic          accept;
    logic          last_cnt;
    logic          out_free;

    function automatic logic [AW-1:0] idx_ext_rmw(input logic [IDX_W-1:0] idx);
        logic [EW-1:0] wide;
        wide = {{AW{1'b0}}, idx};
        return wide[AW-1:0];
    endfunction

    assign idx_ext  = {{AW{1'b0}}, s_data.actuator_index};
    assign idx_ok   = idx_ext < EW'(ACTUATORS);
    assign s_ready  = state_reg == ST_IDLE;
    assign accept   = s_valid && s_ready;
    assign last_cnt = cnt_reg == AW'(ACTUATORS - 1);
    assign out_free = !m_valid_reg || m_ready;

    afsa_store #(
        .DEPTH (ACTUATORS),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    afsa_update u_update (
        .item      (item_reg),
        .old_entry (rd_data),
        .new_entry (upd_entry),
        .changed   (upd_changed)
    );

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pending_next   = pending_reg;
        walk_data_next = 1'b0;
        acc_next       = walk_data_reg ? (acc_reg | rd_data.flags) : acc_reg;
        item_next      = item_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg;
        wr_data        = RESET_ENTRY;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg;
        case (state_reg)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                cnt_next = AW'(cnt_reg + 1'b1);
                if (last_cnt) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.command == CMD_LOG) begin
                        if (pending_reg) begin
                            pending_next = 1'b0;
                            cnt_next     = '0;
                            acc_next     = '0;
                            state_next   = ST_WALK;
                        end
                    end else if (idx_ok) begin
                        rd_en      = 1'b1;
                        rd_addr    = idx_ext[AW-1:0];
                        item_next  = s_data;
                        state_next = ST_RMW;
                    end
                end
            end
            ST_RMW: begin
                wr_en   = upd_changed;
                wr_addr = idx_ext_rmw(item_reg.actuator_index);
                wr_data = upd_entry;
                if (upd_changed) begin
                    pending_next = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_WALK: begin
                rd_en          = 1'b1;
                walk_data_next = 1'b1;
                cnt_next       = AW'(cnt_reg + 1'b1);
                if (last_cnt) begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!walk_data_reg && out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{any_flags: acc_reg, any_warning: |acc_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            pending_reg   <= 1'b0;
            walk_data_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pending_reg   <= pending_next;
            walk_data_reg <= walk_data_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        item_reg   <= item_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_rmw_after_accept : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RMW |-> $past(s_valid && s_ready))
        else $error("write-back without an accepted status word");

    a_result_from_walk : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the end of a walk");

    a_warning_matches : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.any_warning == (|m_data.any_flags))
        else $error("any_warning does not match the aggregate flags");

    a_log_clears_pending : assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.command == CMD_LOG && pending_reg
        |=> !pending_reg && state_reg == ST_WALK)
        else $error("log word did not start a walk and clear pending");
`endif

endmodule

### src/afsa_store.sv
// ----------------------------------------------------------------------------
// afsa_store
// Per-actuator entry memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module afsa_store
    import afsa_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/afsa_update.sv
// ----------------------------------------------------------------------------
// afsa_update
// Decodes one status word into the flags of an entry and flags a change.
// ----------------------------------------------------------------------------
module afsa_update
    import afsa_pkg::*;
(
    input  in_word_t item,
    input  entry_t   old_entry,
    output entry_t   new_entry,
    output logic     changed
);

    logic [WORD_W-1:0] s;
    logic [WORD_W-1:0] f;
    logic [BYTE_W-1:0] v;
    logic              warn;

    assign s    = item.status_word;
    assign f    = item.fault_word;
    assign warn = item.status_word[7:4] != item.broadcast_count;
    assign v    = {3'b000, warn, item.status_word[3:0]};

    always_comb begin
        new_entry = old_entry;
        changed   = 1'b0;
        case (item.command)
            CMD_SERVER: begin
                if (old_entry.server != s) begin
                    changed               = 1'b1;
                    new_entry.server      = s;
                    new_entry.flags[0]    = s[0];
                    new_entry.flags[1]    = s[1];
                    new_entry.flags[2]    = s[3];
                    new_entry.flags[3]    = s[4];
                    new_entry.flags[4]    = s[5];
                    new_entry.flags[5]    = s[13];
                    new_entry.flags[6]    = s[14];
                    new_entry.flags[13:7] = f[6:0];
                    new_entry.flags[16:14] = f[10:8];
                    new_entry.flags[18:17] = f[13:12];
                end
            end
            CMD_DEMAND: begin
                if (old_entry.demand != v) begin
                    changed             = 1'b1;
                    new_entry.demand    = v;
                    new_entry.flags[28] = v[0];
                    new_entry.flags[5]  = v[1];
                    new_entry.flags[29] = v[4];
                end
            end
            CMD_DCA: begin
                if (old_entry.dca != s) begin
                    changed                = 1'b1;
                    new_entry.dca          = s;
                    new_entry.flags[22:19] = s[4:1];
                    new_entry.flags[25:23] = s[8:6];
                    new_entry.flags[27:26] = s[13:12];
                    new_entry.flags[6]     = s[15];
                end
            end
            default: begin
                changed = 1'b0;
            end
        endcase
    end

endmodule

### tb/actuator_fault_status_aggregator_top_tb.sv
// ----------------------------------------------------------------------------
// actuator_fault_status_aggregator_top_tb
// Self-checking bench for the fault status aggregator. It sends server,
// demand and DCA status words plus log requests, and tracks the per-actuator
// flag store and the pending mark for each accepted word. Every aggregate
// result is checked field by field, in order, against the tracked state.
// Both channels idle at random, and the receiver holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module actuator_fault_status_aggregator_top_tb
    import afsa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACTUATORS    = 256;
    localparam int RANDOM_ITEMS = 1350;
    localparam int HOLD_LEN     = 1500;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int DRAIN_LIMIT  = 20000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    in_word_t  stimulus[$];
    out_word_t expected_aggregates[$];

    logic [FLAG_W-1:0] flag_mem[ACTUATORS];
    logic [WORD_W-1:0] server_seen[ACTUATORS];
    logic [BYTE_W-1:0] demand_seen[ACTUATORS];
    logic [WORD_W-1:0] dca_seen[ACTUATORS];
    logic              publish_due;

    int total_words   = 0;
    int words_taken   = 0;
    int status_count  = 0;
    int log_count     = 0;
    int results_seen  = 0;
    int fail_count    = 0;
    int cycle_count   = 0;
    int hold_cycles   = 0;
    bit hold_started  = 1'b0;

    actuator_fault_status_aggregator_top #(
        .ACTUATORS(ACTUATORS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic push_word(input cmd_t c, input int idx, input logic [WORD_W-1:0] s,
                             input logic [WORD_W-1:0] f, input logic [COUNT_W-1:0] cnt);
        in_word_t w;
        w.command         = c;
        w.actuator_index  = idx[IDX_W-1:0];
        w.status_word     = s;
        w.fault_word      = f;
        w.broadcast_count = cnt;
        stimulus.push_back(w);
    endtask

    function automatic logic [WORD_W-1:0] sparse_word();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6) begin
            return WORD_W'($urandom & $urandom & $urandom);
        end else if (pick < 7) begin
            return '0;
        end
        return WORD_W'($urandom);
    endfunction

    function automatic int send_idle_pct();
        if (words_taken < total_words / 3) begin
            return 12;
        end else if (words_taken < (2 * total_words) / 3) begin
            return 61;
        end
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (words_taken < total_words / 3) begin
            return 61;
        end else if (words_taken < (2 * total_words) / 3) begin
            return 12;
        end
        return 0;
    endfunction

    task automatic predict_word(input in_word_t w);
        logic [FLAG_W-1:0] x;
        logic [FLAG_W-1:0] agg;
        logic [WORD_W-1:0] s;
        logic [WORD_W-1:0] f;
        logic [BYTE_W-1:0] v;
        out_word_t         r;
        int                a;
        int                i;
        a   = w.actuator_index;
        s   = w.status_word;
        f   = w.fault_word;
        agg = '0;
        if (cmd_t'(w.command) == CMD_LOG) begin
            log_count++;
            if (publish_due) begin
                for (i = 0; i < ACTUATORS; i++) begin
                    agg |= flag_mem[i];
                end
                r.any_flags   = agg;
                r.any_warning = (agg != '0);
                expected_aggregates.push_back(r);
                publish_due = 1'b0;
            end
            return;
        end
        status_count++;
        if (a >= ACTUATORS) begin
            return;
        end
        x = flag_mem[a];
        case (cmd_t'(w.command))
            CMD_SERVER: begin
                if (server_seen[a] == s) begin
                    return;
                end
                x[0]    = s[0];
                x[1]    = s[1];
                x[2]    = s[3];
                x[3]    = s[4];
                x[4]    = s[5];
                x[5]    = s[13];
                x[6]    = s[14];
                x[13:7] = f[6:0];
                x[14]   = f[8];
                x[15]   = f[9];
                x[16]   = f[10];
                x[17]   = f[12];
                x[18]   = f[13];
                server_seen[a] = s;
            end
            CMD_DEMAND: begin
                v = {3'b000, (s[7:4] != w.broadcast_count), s[3:0]};
                if (demand_seen[a] == v) begin
                    return;
                end
                x[28] = v[0];
                x[5]  = v[1];
                x[29] = v[4];
                demand_seen[a] = v;
            end
            default: begin
                if (dca_seen[a] == s) begin
                    return;
                end
                x[22:19] = s[4:1];
                x[23]    = s[6];
                x[24]    = s[7];
                x[25]    = s[8];
                x[26]    = s[12];
                x[27]    = s[13];
                x[6]     = s[15];
                dca_seen[a] = s;
            end
        endcase
        flag_mem[a] = x;
        publish_due = 1'b1;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_word(s_data);
                words_taken <= words_taken + 1;
            end
            if (!s_valid || s_ready) begin
                if (stimulus.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
                    s_valid <= 1'b1;
                    s_data  <= stimulus.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (aresetn && !hold_started && total_words != 0 &&
            words_taken >= (2 * total_words) / 3 + 40) begin
            hold_started <= 1'b1;
            hold_cycles  <= HOLD_LEN;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_aggregates.size() == 0) begin
                    report_mismatch("unexpected result", 32'(m_data), '0);
                end else begin
                    want = expected_aggregates.pop_front();
                    if (m_data.any_flags !== want.any_flags) begin
                        report_mismatch("any_flags", 32'(m_data.any_flags),
                                        32'(want.any_flags));
                    end
                    if (m_data.any_warning !== want.any_warning) begin
                        report_mismatch("any_warning", 32'(m_data.any_warning),
                                        32'(want.any_warning));
                    end
                end
            end
            m_ready <= (hold_cycles > 0) ? 1'b0 : ($urandom_range(99) >= recv_idle_pct());
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        cmd_t              kind;
        logic [WORD_W-1:0] s;
        logic [WORD_W-1:0] f;
        logic [COUNT_W-1:0] cnt;
        logic [WORD_W-1:0] recent[3];
        int                pick;
        int                idx;
        int                target;
        int                drain;

        for (int i = 0; i < ACTUATORS; i++) begin
            flag_mem[i]    = '0;
            server_seen[i] = 16'hFFFF;
            demand_seen[i] = 8'hFF;
            dca_seen[i]    = 16'hFFFF;
        end
        publish_due = 1'b0;
        recent[0] = '0;
        recent[1] = '0;
        recent[2] = '0;

        // log while idle, unchanged words, ignored fault word
        push_word(CMD_LOG,    0,   16'h0000, 16'h0000, 4'h0);
        push_word(CMD_SERVER, 0,   16'hFFFF, 16'hFFFF, 4'hF);
        push_word(CMD_LOG,    255, 16'hFFFF, 16'hFFFF, 4'hF);
        push_word(CMD_SERVER, 0,   16'h603B, 16'h377F, 4'h0);
        push_word(CMD_LOG,    0,   16'h0000, 16'h0000, 4'h0);
        push_word(CMD_SERVER, 0,   16'h603B, 16'h0000, 4'h0);
        push_word(CMD_LOG,    0,   16'h0000, 16'h0000, 4'h0);
        // counter match and mismatch, upper byte dropped
        push_word(CMD_DEMAND, 255, 16'hFFA3, 16'h0000, 4'hA);
        push_word(CMD_DEMAND, 255, 16'h00F3, 16'hFFFF, 4'h3);
        push_word(CMD_LOG,    0,   16'h0000, 16'h0000, 4'h0);
        push_word(CMD_DCA,    128, 16'hFFFF, 16'h0000, 4'h0);
        push_word(CMD_DCA,    128, 16'h0000, 16'h0000, 4'h0);
        push_word(CMD_DCA,    128, 16'hB1DE, 16'h0000, 4'h0);
        push_word(CMD_LOG,    0,   16'h0000, 16'h0000, 4'h0);
        // shared mezzanine error and bootloader flags
        push_word(CMD_SERVER, 0,   16'h0000, 16'h0000, 4'h0);
        push_word(CMD_DEMAND, 0,   16'h0002, 16'h0000, 4'h0);
        push_word(CMD_LOG,    0,   16'h0000, 16'h0000, 4'h0);
        push_word(CMD_DCA,    0,   16'h8000, 16'h0000, 4'h0);
        push_word(CMD_LOG,    0,   16'h0000, 16'h0000, 4'h0);
        push_word(CMD_SERVER, 0,   16'h4000, 16'h0000, 4'h0);
        push_word(CMD_DCA,    0,   16'h0000, 16'h0000, 4'h0);
        push_word(CMD_LOG,    0,   16'h0000, 16'h0000, 4'h0);
        // clear everything, aggregate back to zero
        push_word(CMD_SERVER, 0,   16'h0000, 16'h0000, 4'h0);
        push_word(CMD_SERVER, 255, 16'h0000, 16'h0000, 4'h0);
        push_word(CMD_DEMAND, 255, 16'h0000, 16'h0000, 4'h0);
        push_word(CMD_DEMAND, 0,   16'h0000, 16'h0000, 4'h0);
        push_word(CMD_DCA,    128, 16'h0000, 16'h0000, 4'h0);
        push_word(CMD_LOG,    0,   16'h0000, 16'h0000, 4'h0);

        target = stimulus.size() + RANDOM_ITEMS;
        while (stimulus.size() < target) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                push_word(CMD_LOG, $urandom_range(255), WORD_W'($urandom),
                          WORD_W'($urandom), COUNT_W'($urandom));
            end else begin
                kind = cmd_t'($urandom_range(2));
                pick = $urandom_range(99);
                if (pick < 55) begin
                    idx = $urandom_range(3);
                end else if (pick < 75) begin
                    idx = 252 + $urandom_range(3);
                end else begin
                    idx = $urandom_range(255);
                end
                s = sparse_word();
                f = sparse_word();
                if ($urandom_range(3) == 0) begin
                    s = recent[kind];
                end
                cnt = $urandom_range(1) ? s[7:4] : COUNT_W'($urandom_range(15));
                push_word(kind, idx, s, f, cnt);
                recent[kind] = s;
                if (idx >= 4 && idx < 252 && $urandom_range(9) < 7) begin
                    push_word(CMD_SERVER, idx, '0, '0, '0);
                    push_word(CMD_DEMAND, idx, '0, '0, '0);
                    push_word(CMD_DCA,    idx, '0, '0, '0);
                end
            end
        end
        total_words = stimulus.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (stimulus.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        drain = 0;
        while (expected_aggregates.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (ACTUATORS + 16) @(posedge aclk);
        if (expected_aggregates.size() != 0) begin
            report_mismatch("results still outstanding", expected_aggregates.size(), 0);
        end

        $display("sent %0d words: %0d status updates and %0d log requests; %0d aggregates checked",
                 words_taken, status_count, log_count, results_seen);
        $display("idling on both sides in both mixes, then none, with one %0d-cycle hold-off",
                 HOLD_LEN);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
src/afsa_pkg.sv
src/afsa_store.sv
src/afsa_update.sv
src/actuator_fault_status_aggregator_top.sv
tb/actuator_fault_status_aggregator_top_tb.sv
